FILE: rtl/vsdb_pkg.sv
// vsdb_pkg: shared widths, register codes and structs for the sphere dig brush
// used by every module under rtl/; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package vsdb_pkg;

  localparam int CW        = 28;
  localparam int RW        = 20;
  localparam int PW        = 11;
  localparam int NCW       = 7;
  localparam int PTW       = 7;
  localparam int CKW       = 8;
  localparam int DW        = 8;
  localparam int LINW      = 17;
  localparam int POSW      = 29;
  localparam int DIFW      = 34;
  localparam int ABW       = 20;
  localparam int SQW       = 2 * ABW;
  localparam int D2W       = SQW + 2;
  localparam int IN_TW     = 56;
  localparam int OUT_TW    = 16;
  localparam int CFG_AW    = 3;
  localparam int DIST_FRAC = 11;
  localparam int Q_DEPTH   = 4;
  localparam int QAW       = 2;

  localparam logic [RW-1:0]  RADIUS_RST = 20'd1600;
  localparam logic [PW-1:0]  PITCH_RST  = 11'd100;
  localparam logic [NCW-1:0] CELLS_RST  = 7'd32;

  typedef enum logic [CFG_AW-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_RADIUS   = 3'd3,
    REG_PITCH    = 3'd4,
    REG_CELLS    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] cz;
    logic [RW-1:0]        radius;
    logic [PW-1:0]        pitch;
    logic [NCW-1:0]       cells;
  } vsdb_cfg_t;

  typedef struct packed {
    logic [D2W-1:0] d2;
    logic           in_sph;
    logic [DW-1:0]  dens;
  } vsdb_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } vsdb_q_stat_t;

endpackage

`default_nettype wire

FILE: rtl/vsdb_front.sv
// vsdb_front: takes point requests, forms squared distance and the inside test
// depends on vsdb_pkg
`timescale 1ns / 1ps
`default_nettype none

module vsdb_front
  import vsdb_pkg::*;
#(
  parameter int MAX_GRID_CELLS = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire vsdb_cfg_t         cfg,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [IN_TW-1:0]  in_tdata,
  input  wire logic              q_full,
  output logic                   push,
  output vsdb_item_t             push_item
);

  localparam logic [7:0] MAXC = 8'(MAX_GRID_CELLS);

  logic [4:0] v_r;
  logic       ce;

  logic [7:0]                    cells_c;
  logic [PTW-1:0]                point [3];
  logic [CKW-1:0]                chunk [3];
  logic signed [LINW-1:0]        lin_nxt [3];
  logic signed [LINW-1:0]        lin_r [3];
  logic signed [POSW-1:0]        pos_r [3];
  logic signed [CW-1:0]          cen [3];
  logic [ABW-1:0]                ab_nxt [3];
  logic [ABW-1:0]                ab_r [3];
  logic                          far_nxt, far_r, far3_r;
  logic [SQW-1:0]                sq_r [3];
  logic [SQW-1:0]                rsq_r;
  logic [DW-1:0]                 dens_r [4];
  logic [D2W-1:0]                sum;
  vsdb_item_t                    item_r;

  assign ce        = !(v_r[4] && q_full);
  assign in_tready = ce;
  assign push      = v_r[4] && !q_full;
  assign push_item = item_r;

  assign cen[0] = cfg.cx;
  assign cen[1] = cfg.cy;
  assign cen[2] = cfg.cz;

  always_comb begin
    logic signed [LINW-1:0] ck, cs, pt;
    logic signed [DIFW-1:0] dd;
    logic [DIFW-1:0]        mag;
    cells_c = ({1'b0, cfg.cells} > MAXC) ? MAXC : {1'b0, cfg.cells};
    far_nxt = 1'b0;
    for (int a = 0; a < 3; a++) begin
      point[a]   = in_tdata[a*PTW +: PTW];
      chunk[a]   = in_tdata[3*PTW + a*CKW +: CKW];
      ck         = LINW'(signed'(chunk[a]));
      cs         = LINW'(signed'({1'b0, cells_c}));
      pt         = LINW'(signed'({1'b0, point[a]}));
      lin_nxt[a] = ck * cs + pt;
      dd         = (DIFW'(pos_r[a]) <<< 4) - DIFW'(cen[a]);
      mag        = dd[DIFW-1] ? unsigned'(-dd) : unsigned'(dd);
      far_nxt    = far_nxt | (|mag[DIFW-1:ABW]);
      ab_nxt[a]  = mag[ABW-1:0];
    end
    sum = D2W'(sq_r[0]) + D2W'(sq_r[1]) + D2W'(sq_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (ce) begin
      v_r <= {v_r[3:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    rsq_r <= SQW'(cfg.radius) * SQW'(cfg.radius);
    if (ce) begin
      for (int a = 0; a < 3; a++) begin
        lin_r[a] <= lin_nxt[a];
        pos_r[a] <= POSW'(lin_r[a]) * POSW'(signed'({1'b0, cfg.pitch}));
        ab_r[a]  <= ab_nxt[a];
        sq_r[a]  <= SQW'(ab_r[a]) * SQW'(ab_r[a]);
      end
      far_r     <= far_nxt;
      far3_r    <= far_r;
      dens_r[0] <= in_tdata[IN_TW-4 -: DW];
      for (int s = 1; s < 4; s++) begin
        dens_r[s] <= dens_r[s-1];
      end
      item_r.in_sph <= !far3_r && (sum <= D2W'(rsq_r));
      item_r.d2     <= (!far3_r && (sum <= D2W'(rsq_r))) ? sum : '0;
      item_r.dens   <= dens_r[3];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/vsdb_fifo.sv
// vsdb_fifo: short queue of classified points between front and back
// depends on vsdb_pkg
`timescale 1ns / 1ps
`default_nettype none

module vsdb_fifo
  import vsdb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire vsdb_item_t  push_item,
  input  wire logic        pop,
  output vsdb_item_t       head,
  output vsdb_q_stat_t     stat
);

  vsdb_item_t     mem [Q_DEPTH];
  logic [QAW-1:0] wr_r, rd_r;
  logic [QAW:0]   cnt_r;

  assign stat.full  = (cnt_r == (QAW+1)'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head       = mem[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/vsdb_back.sv
// vsdb_back: square root, ratio divide, smoothstep and density update
// depends on vsdb_pkg
`timescale 1ns / 1ps
`default_nettype none

module vsdb_back
  import vsdb_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [RW-1:0]      radius,
  input  wire vsdb_item_t         head,
  input  wire logic               q_empty,
  output logic                    pop,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [OUT_TW-1:0]       out_tdata
);

  localparam int SQ_IT = 32;
  localparam int NBW   = 64;
  localparam int SW    = 31;
  localparam int DV_IT = FRAC_BITS + 1;
  localparam int DVW   = 32 + FRAC_BITS;
  localparam int QW    = FRAC_BITS + 1;
  localparam int TW    = FRAC_BITS + 2;
  localparam int AW    = QW + 9;
  localparam int TOT   = SQ_IT + DV_IT + 2;
  localparam logic [QW-1:0] ONE  = QW'(1) << FRAC_BITS;
  localparam logic [AW-1:0] HALF = AW'(1) << (FRAC_BITS - 1);

  logic ce;
  logic [TOT-1:0]  v_r;
  logic [DW-1:0]   dens_r [TOT];
  logic [TOT-1:0]  ins_r;

  logic [NBW-1:0]  sn_nxt [SQ_IT];
  logic [NBW-1:0]  sr_nxt [SQ_IT];
  logic [NBW-1:0]  sn_r [SQ_IT];
  logic [NBW-1:0]  sr_r [SQ_IT];
  logic [DVW-1:0]  dr_nxt [DV_IT];
  logic [QW-1:0]   dq_nxt [DV_IT];
  logic [DVW-1:0]  dr_r [DV_IT];
  logic [QW-1:0]   dq_r [DV_IT];

  logic [QW-1:0]   ratio, sq_nxt, sq_r;
  logic [TW-1:0]   t_nxt, t_r, p_nxt, p_r;
  logic [QW-1:0]   alpha;
  logic [AW-1:0]   a255;
  logic [DW-1:0]   delta, nd;
  logic            out_valid_r;
  logic [OUT_TW-1:0] out_data_r;
  logic [OUT_TW-1:0] out_nxt;

  assign ce         = !out_valid_r || out_tready;
  assign pop        = ce && !q_empty;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // bit-pair square root, one result bit per stage
  always_comb begin
    logic [NBW-1:0] n_in, res_in, bitv, trial;
    for (int k = 0; k < SQ_IT; k++) begin
      n_in   = (k == 0) ? (NBW'(head.d2) << (2 * DIST_FRAC)) : sn_r[(k == 0) ? 0 : k-1];
      res_in = (k == 0) ? '0 : sr_r[(k == 0) ? 0 : k-1];
      bitv   = NBW'(1) << (62 - 2*k);
      trial  = res_in + bitv;
      if (n_in >= trial) begin
        sn_nxt[k] = n_in - trial;
        sr_nxt[k] = (res_in >> 1) + bitv;
      end else begin
        sn_nxt[k] = n_in;
        sr_nxt[k] = res_in >> 1;
      end
    end
  end

  // restoring divide, quotient msb first
  always_comb begin
    logic [DVW-1:0] rem_in, trial;
    logic [QW-1:0]  q_in;
    for (int j = 0; j < DV_IT; j++) begin
      rem_in = (j == 0) ? (DVW'(sr_r[SQ_IT-1][SW-1:0]) << FRAC_BITS)
                        : dr_r[(j == 0) ? 0 : j-1];
      q_in   = (j == 0) ? '0 : dq_r[(j == 0) ? 0 : j-1];
      trial  = (DVW'(radius) << DIST_FRAC) << (FRAC_BITS - j);
      if (rem_in >= trial) begin
        dr_nxt[j] = rem_in - trial;
        dq_nxt[j] = {q_in[QW-2:0], 1'b1};
      end else begin
        dr_nxt[j] = rem_in;
        dq_nxt[j] = {q_in[QW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    logic [2*QW-1:0]    rr;
    logic [QW+TW-1:0]   prod;
    logic [DW:0]        dfull;
    if (radius == '0)                  ratio = '0;
    else if (dq_r[DV_IT-1] > ONE)      ratio = ONE;
    else                               ratio = dq_r[DV_IT-1];
    rr     = (2*QW)'(ratio) * (2*QW)'(ratio);
    sq_nxt = QW'(rr >> FRAC_BITS);
    t_nxt  = TW'(3) * TW'(ONE) - (TW'(ratio) << 1);
    prod   = (QW+TW)'(sq_r) * (QW+TW)'(t_r);
    p_nxt  = TW'(prod >> FRAC_BITS);
    alpha  = (p_r > TW'(ONE)) ? '0 : ONE - QW'(p_r);
    a255   = (AW'(alpha) << 8) - AW'(alpha) + HALF;
    dfull  = (DW+1)'(a255 >> FRAC_BITS);
    delta  = (dfull > (DW+1)'(255)) ? DW'(255) : dfull[DW-1:0];
    nd     = (dens_r[TOT-1] > delta) ? dens_r[TOT-1] - delta : '0;
    out_nxt = '0;
    if (ins_r[TOT-1]) begin
      out_nxt[DW-1:0] = nd;
      out_nxt[DW]     = (nd < dens_r[TOT-1]);
      out_nxt[DW+1]   = 1'b1;
    end else begin
      out_nxt[DW-1:0] = dens_r[TOT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (ce) begin
      v_r         <= {v_r[TOT-2:0], pop};
      out_valid_r <= v_r[TOT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      dens_r[0] <= head.dens;
      ins_r     <= {ins_r[TOT-2:0], head.in_sph};
      for (int s = 1; s < TOT; s++) begin
        dens_r[s] <= dens_r[s-1];
      end
      for (int k = 0; k < SQ_IT; k++) begin
        sn_r[k] <= sn_nxt[k];
        sr_r[k] <= sr_nxt[k];
      end
      for (int j = 0; j < DV_IT; j++) begin
        dr_r[j] <= dr_nxt[j];
        dq_r[j] <= dq_nxt[j];
      end
      sq_r       <= sq_nxt;
      t_r        <= t_nxt;
      p_r        <= p_nxt;
      out_data_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/voxel_sphere_dig_brush.sv
// voxel_sphere_dig_brush: one grid point in, one lowered density out.
// Input requests arrive on in_tvalid/in_tready/in_tdata; tdata from bit 0 up:
// point_x, point_y, point_z (7 bits each), chunk_x, chunk_y, chunk_z (8 bits
// each), current_density (8 bits), three zero bits. Results leave on the out_
// channel with new_density, changed, inside_res from bit 0 up.
// Registers are written through cfg_we/cfg_addr/cfg_wdata; the user must
// write them only while idle, as the block itself does not enforce it.
// Throughput is one point per clock while the output is not stalled. A point
// passes five front stages, the queue, one square root bit per stage, one
// quotient bit per stage, two multiply stages and the output register.
// The front feeds a four-entry queue, so in_tready stays high until
// that queue fills while the receiver stalls; the back holds its whole
// pipeline in place while out_tvalid is high and out_tready is low.
// Reset clears all valid state and loads the register defaults; no item
// is in flight afterward.
`timescale 1ns / 1ps
`default_nettype none

module voxel_sphere_dig_brush
  import vsdb_pkg::*;
#(
  parameter int MAX_GRID_CELLS = 64,
  parameter int FRAC_BITS      = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [IN_TW-1:0]   in_tdata,   // px, py, pz, cx, cy, cz, density
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [OUT_TW-1:0]       out_tdata,  // new_density, changed, inside_res
  input  wire logic               cfg_we,
  input  wire logic [CFG_AW-1:0]  cfg_addr,
  input  wire logic [CW-1:0]      cfg_wdata
);

  vsdb_cfg_t    cfg_r;
  vsdb_item_t   push_item, head;
  vsdb_q_stat_t q_stat;
  logic         push, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cx     <= '0;
      cfg_r.cy     <= '0;
      cfg_r.cz     <= '0;
      cfg_r.radius <= RADIUS_RST;
      cfg_r.pitch  <= PITCH_RST;
      cfg_r.cells  <= CELLS_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_CENTER_X: cfg_r.cx     <= signed'(cfg_wdata);
        REG_CENTER_Y: cfg_r.cy     <= signed'(cfg_wdata);
        REG_CENTER_Z: cfg_r.cz     <= signed'(cfg_wdata);
        REG_RADIUS:   cfg_r.radius <= cfg_wdata[RW-1:0];
        REG_PITCH:    cfg_r.pitch  <= cfg_wdata[PW-1:0];
        REG_CELLS:    cfg_r.cells  <= cfg_wdata[NCW-1:0];
        default: ;
      endcase
    end
  end

  vsdb_front #(.MAX_GRID_CELLS(MAX_GRID_CELLS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_stat.full),
    .push      (push),
    .push_item (push_item)
  );

  vsdb_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  vsdb_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .radius     (cfg_r.radius),
    .head       (head),
    .q_empty    (q_stat.empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_q_stat: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue both full and empty");

  a_changed_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[8]) |-> out_tdata[9])
    else $error("density lowered outside the sphere");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OUT_TW-1:10] == '0))
    else $error("result padding not zero");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire
